>>> rtl/core/fnfc_pkg.sv
`timescale 1ns / 1ps

package fnfc_pkg;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned COEF_W      = 20;
  localparam int unsigned DYN_W       = 16;
  localparam int unsigned AMP_W       = 24;
  localparam int unsigned ACT_W       = 5;
  localparam int unsigned STAGE_IDX_W = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned SCALE_SHIFT = 28;
  localparam int unsigned COEF_SHIFT  = 17;

  // width of a rounded value before saturation
  localparam int unsigned RND_W = 48;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd1;
  localparam logic [AMP_W-1:0] AMP_RESET = 24'd65536;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_A0 = 2'd0,
    SEL_A1 = 2'd1,
    SEL_B1 = 2'd2
  } coef_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_STAGES = 1'b0,
    CFG_AMPLITUDE     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                          cmd;
    logic [STAGE_IDX_W-1:0]        stage_index;
    logic [1:0]                    coef_select;
    logic signed [COEF_W-1:0]      coef_value;
    logic signed [SAMPLE_W-1:0]    noise_sample;
    logic [DYN_W-1:0]              dyn_scale;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       saturated;
  } out_beat_t;

  // sample moving between neighboring cells
  typedef struct packed {
    logic                       valid;
    logic                       sat;
    logic signed [SAMPLE_W-1:0] x;
  } link_t;

  typedef struct packed {
    logic                     en;
    logic [1:0]               sel;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  typedef struct packed {
    logic                       sat;
    logic signed [SAMPLE_W-1:0] value;
  } sat_t;

  // clamp a rounded value to the signed sample range
  function automatic sat_t sat_clamp(input logic signed [RND_W-1:0] v);
    sat_t r;
    logic [RND_W-SAMPLE_W:0] hi;
    hi = v[RND_W-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      r.sat   = 1'b0;
      r.value = v[SAMPLE_W-1:0];
    end else begin
      r.sat   = 1'b1;
      r.value = v[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/fnfc_scaler.sv
`timescale 1ns / 1ps

module fnfc_scaler (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [fnfc_pkg::SAMPLE_W-1:0]    noise_i,
  input  logic [fnfc_pkg::DYN_W-1:0]              dyn_i,
  input  logic [fnfc_pkg::AMP_W-1:0]              amp_i,
  output fnfc_pkg::link_t                         link_o
);
  import fnfc_pkg::*;

  localparam int unsigned HALF_AMP = AMP_W / 2;
  localparam int unsigned M1_W     = SAMPLE_W + DYN_W + 1;
  localparam int unsigned PP_W     = M1_W + HALF_AMP + 1;
  localparam int unsigned FULL_W   = M1_W + AMP_W + 1;

  logic                     v1_q, v2_q, out_v_q;
  logic signed [M1_W-1:0]   m1_q;
  logic signed [PP_W-1:0]   lo_q, hi_q;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W:0]   rs;
  sat_t                     res;
  sat_t                     out_q;

  // amplitude product split in two halves to keep each multiplier narrow
  always_comb begin
    full = (FULL_W'(hi_q) <<< HALF_AMP) + FULL_W'(lo_q);
    rs   = (FULL_W + 1)'(full) + ((FULL_W + 1)'(1) <<< (SCALE_SHIFT - 1));
    res  = sat_clamp(RND_W'($signed(rs[FULL_W:SCALE_SHIFT])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q    <= start_i;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m1_q <= noise_i * $signed({1'b0, dyn_i});
    end
    if (v1_q) begin
      lo_q <= m1_q * $signed({1'b0, amp_i[HALF_AMP-1:0]});
      hi_q <= m1_q * $signed({1'b0, amp_i[AMP_W-1:HALF_AMP]});
    end
    if (v2_q) begin
      out_q <= res;
    end
  end

  assign link_o.valid = out_v_q;
  assign link_o.sat   = out_q.sat;
  assign link_o.x     = out_q.value;

endmodule

>>> rtl/core/fnfc_cell.sv
`timescale 1ns / 1ps

module fnfc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fnfc_pkg::coef_wr_t wr_i,
  input  fnfc_pkg::link_t    link_i,
  output fnfc_pkg::link_t    link_o
);
  import fnfc_pkg::*;

  localparam int unsigned PROD_W = COEF_W + SAMPLE_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic signed [COEF_W-1:0]   a0_q, a1_q, b1_q;
  logic signed [SAMPLE_W-1:0] xp_q, yp_q;
  logic signed [PROD_W-1:0]   p0_q, p1_q, p2_q;
  logic                       pv_q, ps_q;
  logic                       out_v_q, out_s_q;
  logic signed [SAMPLE_W-1:0] out_x_q;
  logic signed [SUM_W-1:0]    sum;
  sat_t                       res;

  always_comb begin
    sum = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q) + (SUM_W'(1) <<< (COEF_SHIFT - 1));
    res = sat_clamp(RND_W'($signed(sum[SUM_W-1:COEF_SHIFT])));
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      case (wr_i.sel)
        SEL_A0:  a0_q <= wr_i.value;
        SEL_A1:  a1_q <= wr_i.value;
        SEL_B1:  b1_q <= wr_i.value;
        default: ;
      endcase
    end
  end

  // products use the history from before this beat
  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      p0_q <= a0_q * link_i.x;
      p1_q <= a1_q * xp_q;
      p2_q <= b1_q * yp_q;
      ps_q <= link_i.sat;
    end
    if (pv_q) begin
      out_x_q <= res.value;
      out_s_q <= ps_q | res.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      out_v_q <= 1'b0;
      xp_q    <= '0;
      yp_q    <= '0;
    end else begin
      pv_q    <= link_i.valid;
      out_v_q <= pv_q;
      if (link_i.valid) begin
        xp_q <= link_i.x;
      end
      if (pv_q) begin
        yp_q <= res.value;
      end
    end
  end

  assign link_o.valid = out_v_q;
  assign link_o.sat   = out_s_q;
  assign link_o.x     = out_x_q;

endmodule

>>> rtl/core/flicker_noise_filter_cascade_top.sv
`timescale 1ns / 1ps

// Flicker noise shaper: a sample beat is scaled by its dynamic scale and the
// amplitude register, then run through active_stages pole-zero sections from
// the highest active one down to section 0; a load beat writes one
// coefficient and gives no result. Sections sit in a row of identical cells,
// each with its own coefficients, history and multipliers, and the sample
// walks from cell to cell. One sample is in flight at a time: its result
// reaches the output queue through the scaler's dynamic product, amplitude
// product and round/clamp registers and, in each active cell, a product
// register and then a sum, round and clamp register. The next beat is taken
// in the cycle after the result is pushed, unless the output queue is full.
// A two-beat output queue lets the next beat in while one result waits.
// Coefficients must be loaded before a sample uses them.
module flicker_noise_filter_cascade_top #(
  parameter int unsigned MAX_STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  fnfc_pkg::in_beat_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output fnfc_pkg::out_beat_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [fnfc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fnfc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import fnfc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_STAGES + 1);

  logic [ACT_W-1:0] act_q;
  logic [AMP_W-1:0] amp_q;
  logic [NW-1:0]    n_stages;
  logic             acc, start, load, busy_q;
  logic [1:0]       cnt_q;
  out_beat_t        head_q, tail_q;
  link_t            scl_out, res;
  link_t            cell_in  [MAX_STAGES];
  link_t            cell_out [MAX_STAGES];
  coef_wr_t         cell_wr  [MAX_STAGES];
  logic             push, pop;
  out_beat_t        res_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_RESET;
      amp_q <= AMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_STAGES: act_q <= cfg_data_i[ACT_W-1:0];
        CFG_AMPLITUDE:     amp_q <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_stages = (32'(act_q) > MAX_STAGES) ? NW'(MAX_STAGES) : NW'(act_q);

  assign in_ready_o = !busy_q && (cnt_q != 2'd2);
  assign acc        = in_valid_i && in_ready_o;
  assign start      = acc && (in_data_i.cmd == CMD_SAMPLE);
  assign load       = acc && (in_data_i.cmd == CMD_LOAD);

  fnfc_scaler u_scaler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .noise_i (in_data_i.noise_sample),
    .dyn_i   (in_data_i.dyn_scale),
    .amp_i   (amp_q),
    .link_o  (scl_out)
  );

  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
    localparam int unsigned ID = i;

    // the sample enters at the highest active section
    if (i == MAX_STAGES - 1) begin : g_last
      assign cell_in[i] = (n_stages == NW'(ID + 1)) ? scl_out : '0;
    end else begin : g_mid
      assign cell_in[i] = (n_stages == NW'(ID + 1)) ? scl_out : cell_out[i+1];
    end

    assign cell_wr[i].en    = load && (32'(in_data_i.stage_index) == ID);
    assign cell_wr[i].sel   = in_data_i.coef_select;
    assign cell_wr[i].value = in_data_i.coef_value;

    fnfc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (cell_wr[i]),
      .link_i (cell_in[i]),
      .link_o (cell_out[i])
    );
  end

  assign res = (n_stages == '0) ? scl_out : cell_out[0];

  assign res_beat.filtered_sample = res.x;
  assign res_beat.saturated       = res.sat;

  assign push = res.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
      end else if (push) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // two-beat output queue, head drives the port
  always_ff @(posedge clk_i) begin
    case (cnt_q)
      2'd0: begin
        if (push) begin
          head_q <= res_beat;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_q <= res_beat;
        end else if (push) begin
          tail_q <= res_beat;
        end
      end
      2'd2: begin
        if (pop) begin
          head_q <= tail_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != 2'd2))
    else $error("result pushed into a full output queue");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy_q)
    else $error("sample accepted without marking the chain busy");

  a_result_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> busy_q)
    else $error("result left the chain with no sample in flight");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

endmodule
